FILE: hdl/cdf53_forward_lift_deadzone_assert.svh
// assertion macros shared by the lifting block
`ifndef CDF53_FORWARD_LIFT_DEADZONE_ASSERT_SVH
`define CDF53_FORWARD_LIFT_DEADZONE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CDFL_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("lifting block: same-cycle check failed");

// next-cycle implication, checked outside reset
`define CDFL_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lifting block: next-cycle check failed");

`endif

FILE: hdl/cdfl_pkg.sv
// types, constants and register codes of the cdf 5/3 forward lifting block
`default_nettype none

package cdfl_pkg;

   // sample and coefficient widths
   localparam int SAMPLE_BITS = 24;
   localparam int HIGH_BITS   = SAMPLE_BITS + 2;
   localparam int COEF_BITS   = 8;
   localparam int GATE_BITS   = 8;

   // highpass quantizer: divide by 1024 with half rounding on the magnitude
   localparam int HP_SHIFT      = 10;
   localparam int HP_ROUND_BIAS = 1 << (HP_SHIFT - 1);
   localparam int HP_QBITS      = (HIGH_BITS - HP_SHIFT + 1 > COEF_BITS) ?
                                  (HIGH_BITS - HP_SHIFT + 1) : COEF_BITS;
   localparam logic [COEF_BITS-1:0] HP_POS_LIMIT = 8'd127;
   localparam logic [COEF_BITS-1:0] HP_NEG_LIMIT = 8'd128;

   // lowpass update: floor((h + h_prev + 4) / 8)
   localparam int LP_SHIFT = 3;
   localparam int LP_ROUND = 1 << (LP_SHIFT - 1);

   // decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GATE_LIMIT = '0;
   localparam logic [GATE_BITS-1:0] GATE_RESET = 8'd48;

   // input beat
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] even_sample;
      logic signed [SAMPLE_BITS-1:0] odd_sample;
      logic                          row_end;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] lowpass;
      logic signed [COEF_BITS-1:0]   highpass;
      logic                          last_of_row;
   } rsp_type;

   // one queued job: the held pair, the final pair of a row, or both
   typedef struct packed {
      logic                          has_held;
      logic signed [SAMPLE_BITS-1:0] held_even;
      logic signed [HIGH_BITS-1:0]   held_h;
      logic signed [COEF_BITS-1:0]   held_q;
      logic                          has_end;
      logic signed [SAMPLE_BITS-1:0] end_even;
      logic signed [HIGH_BITS-1:0]   end_h;
      logic signed [COEF_BITS-1:0]   end_q;
   } job_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

endpackage

`default_nettype wire

FILE: hdl/cdfl_csr.sv
// register port holding the highpass gate limit
`default_nettype none

module cdfl_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cdfl_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [cdfl_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [cdfl_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready,
   output logic      [cdfl_pkg::GATE_BITS-1:0]     gate_limit
);

   logic [cdfl_pkg::GATE_BITS-1:0]      gate_ff;
   logic [cdfl_pkg::GATE_BITS-1:0]      gate_in;
   logic [cdfl_pkg::CSR_INDEX_BITS-1:0] reg_index;
   logic                                wr_en;

   // decode
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[cdfl_pkg::CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // gate register write
   always_comb begin
      gate_in = gate_ff;
      if (wr_en && (reg_index == cdfl_pkg::REG_GATE_LIMIT)) begin
         gate_in = csr_pwdata[cdfl_pkg::GATE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= cdfl_pkg::GATE_RESET;
      end else begin
         gate_ff <= gate_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (reg_index == cdfl_pkg::REG_GATE_LIMIT) begin
         csr_prdata = cdfl_pkg::CSR_DATA_BITS'(gate_ff);
      end
   end

   assign gate_limit = gate_ff;

endmodule

`default_nettype wire

FILE: hdl/cdfl_front.sv
// front end: holds the previous pair, forms highpass values and queues jobs
`default_nettype none

module cdfl_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire cdfl_pkg::req_type             req_data,
   input  wire logic [cdfl_pkg::GATE_BITS-1:0] gate_limit,
   input  wire cdfl_pkg::qstat_type           q_stat,
   output logic                               push,
   output cdfl_pkg::job_type                  push_job
);

   localparam int SB = cdfl_pkg::SAMPLE_BITS;
   localparam int HB = cdfl_pkg::HIGH_BITS;
   localparam int QB = cdfl_pkg::HP_QBITS;
   localparam int CB = cdfl_pkg::COEF_BITS;

   logic signed [SB-1:0] held_even_ff, held_even_in;
   logic signed [SB-1:0] held_odd_ff, held_odd_in;
   logic                 pending_ff, pending_in;
   logic                 accept;
   logic signed [HB-1:0] held_h;
   logic signed [HB-1:0] end_h;

   // quantize a highpass: round |h|/1024, clamp, gate, restore sign
   function automatic logic [CB-1:0] quantize(input logic signed [HB-1:0] h,
                                              input logic [CB-1:0] gate);
      logic          neg;
      logic [HB-1:0] mag;
      logic [HB:0]   rnd;
      logic [QB-1:0] rq;
      logic [CB-1:0] lim;
      logic [CB-1:0] qm;
      logic [CB-1:0] gated;
      neg   = h[HB-1];
      mag   = neg ? HB'(-h) : HB'(h);
      rnd   = {1'b0, mag} + (HB+1)'(cdfl_pkg::HP_ROUND_BIAS);
      rq    = QB'(rnd >> cdfl_pkg::HP_SHIFT);
      lim   = neg ? cdfl_pkg::HP_NEG_LIMIT : cdfl_pkg::HP_POS_LIMIT;
      qm    = (rq > QB'(lim)) ? lim : rq[CB-1:0];
      gated = (qm < gate) ? '0 : qm;
      return neg ? CB'(-gated) : gated;
   endfunction

   // handshake
   assign req_stall = q_stat.full;
   assign accept    = req_valid & ~q_stat.full;

   // highpass of the held pair and of a row-final pair, in half-lsb units
   assign held_h = (HB'(held_odd_ff) <<< 1) - HB'(held_even_ff) - HB'(req_data.even_sample);
   assign end_h  = (HB'(req_data.odd_sample) - HB'(req_data.even_sample)) <<< 1;

   // job build
   always_comb begin
      push               = accept & (pending_ff | req_data.row_end);
      push_job.has_held  = pending_ff;
      push_job.held_even = held_even_ff;
      push_job.held_h    = held_h;
      push_job.held_q    = quantize(held_h, gate_limit);
      push_job.has_end   = req_data.row_end;
      push_job.end_even  = req_data.even_sample;
      push_job.end_h     = end_h;
      push_job.end_q     = quantize(end_h, gate_limit);
   end

   // held pair update
   always_comb begin
      held_even_in = held_even_ff;
      held_odd_in  = held_odd_ff;
      pending_in   = pending_ff;
      if (accept) begin
         held_even_in = req_data.even_sample;
         held_odd_in  = req_data.odd_sample;
         pending_in   = ~req_data.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      held_even_ff <= held_even_in;
      held_odd_ff  <= held_odd_in;
   end

endmodule

`default_nettype wire

FILE: hdl/cdfl_queue.sv
// short job queue between the front and back ends
`default_nettype none

module cdfl_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cdfl_pkg::job_type push_job,
   input  wire logic              pop,
   output cdfl_pkg::qstat_type    q_stat,
   output cdfl_pkg::job_type      q_head
);

   localparam int PB = cdfl_pkg::QPTR_BITS;
   localparam int NB = cdfl_pkg::QCNT_BITS;

   cdfl_pkg::job_type  slot_ff [cdfl_pkg::QUEUE_DEPTH];
   logic [PB-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0]      count_ff, count_in;

   // status
   assign q_stat.full  = (count_ff == NB'(cdfl_pkg::QUEUE_DEPTH));
   assign q_stat.valid = (count_ff != '0);
   assign q_head       = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(cdfl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(cdfl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/cdfl_back.sv
// back end: emits one or two coefficient pairs per job with the lowpass update
`default_nettype none

`include "cdf53_forward_lift_deadzone_assert.svh"

module cdfl_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cdfl_pkg::qstat_type q_stat,
   input  wire cdfl_pkg::job_type q_head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cdfl_pkg::rsp_type      rsp_data
);

   localparam int SB = cdfl_pkg::SAMPLE_BITS;
   localparam int HB = cdfl_pkg::HIGH_BITS;
   localparam int CB = cdfl_pkg::COEF_BITS;

   logic                 q_valid;
   logic                 phase_ff, phase_in;
   logic signed [HB-1:0] prior_ff, prior_in;
   logic                 row_start_ff, row_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cdfl_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 load;
   logic                 done;
   logic signed [SB-1:0] cur_even;
   logic signed [HB-1:0] cur_h;
   logic signed [CB-1:0] cur_q;
   logic                 cur_last;
   logic signed [HB-1:0] hp;
   logic signed [HB+1:0] lp_sum;
   logic signed [SB:0]   lp_step;
   logic signed [SB:0]   lp_wide;
   logic signed [SB-1:0] lp_sat;

   assign q_valid = q_stat.valid;

   // pick the held pair first, then the row-final pair
   always_comb begin
      if (q_head.has_held && !phase_ff) begin
         cur_even = q_head.held_even;
         cur_h    = q_head.held_h;
         cur_q    = q_head.held_q;
         cur_last = 1'b0;
         done     = ~q_head.has_end;
      end else begin
         cur_even = q_head.end_even;
         cur_h    = q_head.end_h;
         cur_q    = q_head.end_q;
         cur_last = 1'b1;
         done     = 1'b1;
      end
   end

   // lowpass: even + floor((h + h_prev + 4) / 8), saturated; h_prev = h at row start
   assign hp      = row_start_ff ? cur_h : prior_ff;
   assign lp_sum  = (HB+2)'(cur_h) + (HB+2)'(hp) + (HB+2)'(cdfl_pkg::LP_ROUND);
   assign lp_step = (SB+1)'(lp_sum >>> cdfl_pkg::LP_SHIFT);
   assign lp_wide = (SB+1)'(cur_even) + lp_step;

   always_comb begin
      if (lp_wide[SB] != lp_wide[SB-1]) begin
         lp_sat = lp_wide[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end else begin
         lp_sat = lp_wide[SB-1:0];
      end
   end

   // output register and lifting state
   assign load = q_valid & (~rsp_valid_ff | ~rsp_stall);
   assign pop  = load & done;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      phase_in     = phase_ff;
      prior_in     = prior_ff;
      row_start_in = row_start_ff;
      if (load) begin
         rsp_in.lowpass     = lp_sat;
         rsp_in.highpass    = cur_q;
         rsp_in.last_of_row = cur_last;
         rsp_valid_in       = 1'b1;
         phase_in           = ~done;
         prior_in           = cur_h;
         row_start_in       = cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         prior_ff     <= '0;
         row_start_ff <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         prior_ff     <= prior_in;
         row_start_ff <= row_start_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `CDFL_ASSERT_IMPL(a_phase_keeps_job, clock, reset, phase_ff, q_valid)
   `CDFL_ASSERT_IMPL(a_split_job_pop, clock, reset, pop && q_head.has_held && q_head.has_end, phase_ff)
   `CDFL_ASSERT_IMPL(a_phase_mid_row, clock, reset, phase_ff, !row_start_ff)
   `CDFL_ASSERT_NEXT(a_last_restarts_row, clock, reset, load && cur_last, row_start_ff)

endmodule

`default_nettype wire

FILE: hdl/cdf53_forward_lift_deadzone.sv
// top level of the cdf 5/3 forward lifting block with dead-zone highpass
// Usage: one row enters as even/odd sample pairs on req_*, row_end set on
// the final pair. Coefficient pairs leave on rsp_*, last_of_row on the final one.
// A pair's coefficients wait for the next pair's even sample, so the first
// pair of a row gives no beat unless it ends the row; its successor releases
// it, and the row-final pair releases the held pair and then its own pair,
// two beats in a row. A result passes the job queue, then the output register.
// Throughput: one input beat per cycle while the job queue is not full; a
// row-final beat that follows a held pair gives the back end two beats to emit,
// absorbed by the four-entry job queue. The front end stalls req_* only when
// the queue is full; the back end stops when rsp_stall holds the output
// register, which keeps its beat unchanged.
// csr_*: gate_limit at byte address 0, reset 48; write only while idle.
// Reset: clears the queue and output valid, returns the row to its start.
`default_nettype none

module cdf53_forward_lift_deadzone (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire cdfl_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output cdfl_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cdfl_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [cdfl_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [cdfl_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);

   logic [cdfl_pkg::GATE_BITS-1:0] gate_limit;
   cdfl_pkg::qstat_type            q_stat;
   cdfl_pkg::job_type              push_job;
   cdfl_pkg::job_type              q_head;
   logic                           push;
   logic                           pop;

   // register port
   cdfl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gate_limit  (gate_limit)
   );

   // front end
   cdfl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .gate_limit (gate_limit),
      .q_stat     (q_stat),
      .push       (push),
      .push_job   (push_job)
   );

   // job queue
   cdfl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_stat   (q_stat),
      .q_head   (q_head)
   );

   // back end
   cdfl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: tb/sv/cdf53_forward_lift_deadzone_test.sv
// self-checking testbench for the cdf 5/3 forward lifting block with dead-zone highpass
`default_nettype none

module cdf53_forward_lift_deadzone_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cdfl_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam longint SMAX = (longint'(1) << (SB - 1)) - 1;
   localparam longint SMIN = -(longint'(1) << (SB - 1));
   localparam int REG_UNMAPPED = 1;   // register slot with nothing behind it
   localparam int SETTLE = 8;         // cycles the block may still be busy after the last beat
   localparam int STALL_LIMIT = 1000; // cycles without any accepted beat

   // one queued input beat, optionally held back until every result is out
   typedef struct {
      req_type beat;
      bit      drain_first;
   } feed_entry_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // stimulus and expected coefficients
   feed_entry_t pair_feed[$];
   rsp_type coef_expect[$];
   int queued = 0;
   int accepted = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   logic req_taken = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;

   // lifting state mirrored from the block
   longint gate = 48;
   longint held_e = 0;
   longint held_o = 0;
   longint prior_h = 0;
   bit pair_held = 1'b0;
   bit row_fresh = 1'b1;

   cdf53_forward_lift_deadzone dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one coefficient pair: lowpass update and dead-zone quantized highpass
   task automatic emit_coef(input longint ev, input longint h, input bit last);
      longint hp, lp, mag, q;
      rsp_type c;
      hp = row_fresh ? h : prior_h;
      lp = ev + ((h + hp + 4) >>> 3);
      if (lp > SMAX) lp = SMAX;
      if (lp < SMIN) lp = SMIN;
      mag = (h < 0) ? -h : h;
      q = (mag + 512) / 1024;
      if (h < 0) q = -q;
      if (q < -128) q = -128;
      if (q > 127) q = 127;
      if (((q < 0) ? -q : q) < gate) q = 0;
      c.lowpass = SB'(lp);
      c.highpass = 8'(q);
      c.last_of_row = last;
      coef_expect.push_back(c);
      prior_h = h;
      row_fresh = 1'b0;
   endtask

   // accepted sample pair: release the held pair, close the row on row_end
   task automatic lift_pair(input req_type b);
      longint e, o;
      e = $signed(b.even_sample);
      o = $signed(b.odd_sample);
      if (pair_held) emit_coef(held_e, 2 * held_o - held_e - e, 1'b0);
      if (b.row_end) begin
         emit_coef(e, 2 * o - 2 * e, 1'b1);
         pair_held = 1'b0;
         held_e = 0;
         held_o = 0;
         row_fresh = 1'b1;
      end else begin
         held_e = e;
         held_o = o;
         pair_held = 1'b1;
      end
   endtask

   task automatic queue_pair(input longint e, input longint o, input bit last,
                             input bit drain);
      feed_entry_t f;
      f.beat.even_sample = SB'(e);
      f.beat.odd_sample = SB'(o);
      f.beat.row_end = last;
      f.drain_first = drain;
      pair_feed.push_back(f);
      queued++;
   endtask

   // smooth rows stay near a center, rough rows take any value
   function automatic longint draw_sample(input longint center, input bit rough);
      longint v, span;
      if (rough) return $signed(SB'($urandom));
      span = longint'(1) << $urandom_range(4, 17);
      v = center - span + longint'($urandom_range(0, 2 * span));
      if (v > SMAX) v = SMAX;
      if (v < SMIN) v = SMIN;
      return v;
   endfunction

   // random rows until about the wanted number of beats
   task automatic queue_rows(input int want);
      int count, len, k, pick;
      longint center;
      bit rough;
      count = 0;
      while (count < want) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
         rough = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) center = SMAX;
         else if (pick == 1) center = SMIN;
         else center = longint'($urandom_range(0, 2 * SMAX)) - SMAX;
         for (k = 0; k < len; k++) begin
            queue_pair(draw_sample(center, rough), draw_sample(center, rough),
                       k == len - 1, $urandom_range(0, 79) == 0);
            count++;
         end
      end
   endtask

   // apb write: setup cycle, then access cycle
   task automatic csr_write(input int idx, input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(idx * 4);
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == int'(REG_GATE_LIMIT)) gate = val[GATE_BITS-1:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // all beats taken, all coefficients seen, then let the pipeline settle
   task automatic wait_drained();
      while (accepted != queued || coef_expect.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // input driver
   always @(negedge clock) begin : drive_req
      logic next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (send_gap != 0) begin
            send_gap--;
         end else if (pair_feed.size() != 0 &&
                      !(pair_feed[0].drain_first && coef_expect.size() != 0)) begin
            next_data = pair_feed[0].beat;
            next_valid = 1'b1;
            pair_feed.pop_front();
            if (send_idle_on) send_gap = pick_gap();
         end
      end
      req_valid <= next_valid;
      req_data <= next_data;
   end

   // result side back-pressure
   always @(negedge clock) begin : drive_stall
      if (recv_gap != 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (recv_idle_on) recv_gap = pick_gap();
      end
   end

   // predict on accepted input beats, check result beats, watchdog
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            lift_pair(req_data);
            accepted++;
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (coef_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: lowpass %0d highpass %0d last %0d",
                           rsp_data.lowpass, rsp_data.highpass, rsp_data.last_of_row);
            end else begin
               want = coef_expect.pop_front();
               if (rsp_data.lowpass !== want.lowpass || rsp_data.highpass !== want.highpass ||
                   rsp_data.last_of_row !== want.last_of_row) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected lp %0d hp %0d last %0d, got lp %0d hp %0d last %0d",
                              want.lowpass, want.highpass, want.last_of_row,
                              rsp_data.lowpass, rsp_data.highpass, rsp_data.last_of_row);
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // unmapped slot: gate stays at its reset value
      csr_write(REG_UNMAPPED, 0);

      // directed: clamps, saturation, gate edge at 48, ordinary row
      queue_pair(SMAX, SMIN, 1'b1, 1'b0);
      queue_pair(SMIN, SMAX, 1'b1, 1'b0);
      queue_pair(0, 0, 1'b1, 1'b0);
      queue_pair(SMAX, SMAX, 1'b0, 1'b0);
      queue_pair(SMIN, SMIN, 1'b1, 1'b0);
      queue_pair(SMIN, SMIN, 1'b0, 1'b0);
      queue_pair(SMAX, SMAX, 1'b1, 1'b0);
      queue_pair(0, 24320, 1'b1, 1'b1);
      queue_pair(0, 24319, 1'b1, 1'b0);
      queue_pair(0, -24320, 1'b1, 1'b0);
      queue_pair(0, -24319, 1'b1, 1'b0);
      queue_pair(100000, 400000, 1'b0, 1'b0);
      queue_pair(-300000, -900000, 1'b0, 1'b0);
      queue_pair(2000000, 50000, 1'b0, 1'b1);
      queue_pair(-700000, 1500000, 1'b1, 1'b0);
      queue_rows(130);
      wait_drained();

      // gating off, rounding ties on the highpass
      csr_write(REG_GATE_LIMIT, 0);
      queue_pair(0, 256, 1'b1, 1'b0);
      queue_pair(0, -256, 1'b1, 1'b0);
      queue_pair(0, 255, 1'b1, 1'b0);
      queue_pair(0, -255, 1'b1, 1'b0);
      queue_rows(180);
      wait_drained();

      // every highpass gated away but those clamped to -128
      csr_write(REG_GATE_LIMIT, 128);
      queue_rows(100);
      wait_drained();

      csr_write(REG_GATE_LIMIT, 1);
      queue_rows(100);
      wait_drained();

      // back-to-back stretch with no idling on either side
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      csr_write(REG_GATE_LIMIT, $urandom_range(2, 127));
      queue_rows(150);
      wait_drained();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;

      csr_write(REG_GATE_LIMIT, 127);
      queue_rows(100);
      wait_drained();

      if (mismatches == 0 && coef_expect.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/cdfl_pkg.sv
hdl/cdfl_csr.sv
hdl/cdfl_front.sv
hdl/cdfl_queue.sv
hdl/cdfl_back.sv
hdl/cdf53_forward_lift_deadzone.sv
tb/sv/cdf53_forward_lift_deadzone_test.sv
